### src/mbd_pkg.sv
package mbd_pkg;

  localparam int AVERAGE_BITS      = 16;
  localparam int CFG_DATA_BITS     = 4;
  localparam int CFG_INDEX_BITS    = 2;
  localparam int ROW_BITS          = 12;
  localparam int HEIGHT_LOG2_LIMIT = 12;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_WIDTH_LOG2     = 2'd0,
    CFG_HEIGHT_LOG2    = 2'd1,
    CFG_THREE_CHANNELS = 2'd2,
    CFG_UNUSED         = 2'd3
  } cfg_index_t;

endpackage

### src/mip_box_downfilter_top.sv
// The block takes one power-of-two image level as a raster stream with one
// channel value per input beat and gives the next, half-size level as the
// rounded 2x2 box average of each quad; one result beat leaves on the last
// sample of each quad, and level_last marks the final result of the level.
// Sustained rate is one sample per clock while the output is not stalled:
// each sample makes at most one access to the pair-sum line store, a
// single-port-per-direction RAM with a registered read; a result passes the
// read stage and the output register. Writing any register but CFG_UNUSED
// restarts the level at its first sample; stored data is kept.
module mip_box_downfilter_top
  import mbd_pkg::*;
#(
  parameter int MAX_WIDTH    = 4096,
  parameter int MAX_CHANNELS = 3,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [SAMPLE_BITS-1:0]    sample,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [AVERAGE_BITS-1:0]   average,
  output logic                      level_last
);

  localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2 * MAX_CHANNELS;
  localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int CW         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CHW        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int WLOG_MAX   = $clog2(MAX_WIDTH + 1) - 1;
  localparam int PAIR_BITS  = SAMPLE_BITS + 1;
  localparam int TOTAL_BITS = SAMPLE_BITS + 2;
  localparam int WIDE_BITS  = (SAMPLE_BITS > AVERAGE_BITS) ? SAMPLE_BITS : AVERAGE_BITS;

  logic [CFG_DATA_BITS-1:0] width_log2;
  logic [CFG_DATA_BITS-1:0] height_log2;
  logic                     three_channels;

  logic [CW-1:0]       column_count;
  logic [ROW_BITS-1:0] row_count;
  logic [CHW-1:0]      channel_count;
  logic [SAMPLE_BITS-1:0] left_sample [MAX_CHANNELS];

  logic [CFG_DATA_BITS-1:0] wlog;
  logic [CFG_DATA_BITS-1:0] hlog;
  logic [CW-1:0]       wmask;
  logic [ROW_BITS-1:0] hmask;
  logic                multi;
  logic [CHW-1:0]      chan_last;
  logic                width_one;
  logic                height_one;
  logic                accept;
  logic                have_pair;
  logic                emit;
  logic                line_write;
  logic                line_read;
  logic                at_last;
  logic [PAIR_BITS-1:0] pair;
  logic [AW-1:0]       half;
  logic [AW-1:0]       line_addr;
  logic [PAIR_BITS-1:0] line_data;

  logic                 s1_valid;
  logic [PAIR_BITS-1:0] s1_pair;
  logic                 s1_double;
  logic                 s1_last;
  logic                 s1_advance;
  logic [TOTAL_BITS-1:0] total;
  logic [TOTAL_BITS-1:0] rounded;
  logic [WIDE_BITS-1:0]  quarter;

  assign wlog  = (width_log2 > CFG_DATA_BITS'(WLOG_MAX)) ? CFG_DATA_BITS'(WLOG_MAX)
                                                          : width_log2;
  assign hlog  = (height_log2 > CFG_DATA_BITS'(HEIGHT_LOG2_LIMIT))
                 ? CFG_DATA_BITS'(HEIGHT_LOG2_LIMIT) : height_log2;
  assign wmask = ~({CW{1'b1}} << wlog);
  assign hmask = ~({ROW_BITS{1'b1}} << hlog);
  assign multi = three_channels && (MAX_CHANNELS > 1);
  assign chan_last  = multi ? CHW'(((MAX_CHANNELS > 3) ? 3 : MAX_CHANNELS) - 1) : '0;
  assign width_one  = (wlog == '0);
  assign height_one = (hlog == '0);

  assign s1_advance = !out_valid || out_ready;
  assign in_ready   = !s1_valid || s1_advance;
  assign accept     = in_valid && in_ready;

  always_comb begin
    have_pair = 1'b0;
    pair      = '0;
    if (width_one) begin
      have_pair = 1'b1;
      pair      = {sample, 1'b0};
    end else if (column_count[0]) begin
      have_pair = 1'b1;
      pair      = PAIR_BITS'(left_sample[channel_count]) + PAIR_BITS'(sample);
    end
  end

  assign half      = AW'(column_count >> 1);
  assign line_addr = multi ? AW'(half * AW'(MAX_CHANNELS)) + AW'(channel_count)
                           : half + AW'(channel_count);
  assign line_write = accept && have_pair && !height_one && !row_count[0];
  assign line_read  = accept && have_pair && !height_one && row_count[0];
  assign emit       = have_pair && (height_one || row_count[0]);
  assign at_last    = (row_count == hmask) && (column_count == wmask)
                      && (channel_count == chan_last);

  mbd_ram #(
    .WIDTH(PAIR_BITS),
    .DEPTH(LINE_DEPTH)
  ) u_line (
    .clk    (clk),
    .wr_en  (line_write),
    .wr_addr(line_addr),
    .wr_data(pair),
    .rd_en  (line_read),
    .rd_addr(line_addr),
    .rd_data(line_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      width_log2     <= '0;
      height_log2    <= '0;
      three_channels <= 1'b0;
      column_count   <= '0;
      row_count      <= '0;
      channel_count  <= '0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        left_sample[i] <= '0;
      end
    end else if (cfg_write && (cfg_index != CFG_UNUSED)) begin
      unique case (cfg_index)
        CFG_WIDTH_LOG2:     width_log2     <= cfg_data;
        CFG_HEIGHT_LOG2:    height_log2    <= cfg_data;
        CFG_THREE_CHANNELS: three_channels <= cfg_data[0];
        default:            three_channels <= three_channels;
      endcase
      column_count  <= '0;
      row_count     <= '0;
      channel_count <= '0;
    end else if (accept) begin
      if (!width_one && !column_count[0]) begin
        left_sample[channel_count] <= sample;
      end
      if (channel_count == chan_last) begin
        channel_count <= '0;
        if (column_count == wmask) begin
          column_count <= '0;
          row_count    <= (row_count == hmask) ? '0 : row_count + 1'b1;
        end else begin
          column_count <= column_count + 1'b1;
        end
      end else begin
        channel_count <= channel_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pair   <= pair;
      s1_double <= height_one;
      s1_last   <= at_last;
    end
  end

  assign total   = s1_double ? {s1_pair, 1'b0}
                             : TOTAL_BITS'(line_data) + TOTAL_BITS'(s1_pair);
  assign rounded = total + TOTAL_BITS'(2);
  assign quarter = WIDE_BITS'(rounded >> 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_valid) begin
      average    <= quarter[AVERAGE_BITS-1:0];
      level_last <= s1_last;
    end
  end

  a_ready_follows_out: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while the output side is free");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !in_ready) |=> s1_valid)
    else $error("stalled quad result dropped from the read stage");

  a_level_wrap: assert property (@(posedge clk) disable iff (rst)
    (accept && at_last && !cfg_write) |=>
      (column_count == '0) && (row_count == '0) && (channel_count == '0))
    else $error("position counters did not wrap after the last sample");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !s1_valid) |=> !out_valid)
    else $error("result beat repeated after it was taken");

endmodule

### src/mbd_ram.sv
module mbd_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 6144
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### test/tb_top.sv
module tb_top;
  import mbd_pkg::*;

  localparam int MAX_W        = 4096;
  localparam int LINE_SLOTS   = (MAX_W + 1) / 2 * 3;
  localparam int DRAIN_CYCLES = 6;
  localparam int RANDOM_BEATS = 780;
  localparam int PLAN_ROWS    = 38;

  typedef enum logic [1:0] {ROW_WRITE, ROW_FEED, ROW_FEED_CHECKED} row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    cfg_index_t reg_sel;
    logic [3:0] value;
    logic [15:0] smp;
    logic [15:0] avg;
    logic       last;
  } plan_row_t;

  typedef struct packed {
    logic [15:0] avg;
    logic        last;
  } quad_mean_t;

  // Rows with a checked expectation carry their average by hand; plain feed
  // rows are scored by the box filter below.
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{ROW_FEED_CHECKED, CFG_UNUSED,         4'h0, 16'h0000, 16'h0000, 1'b1},
    '{ROW_FEED_CHECKED, CFG_UNUSED,         4'h0, 16'hFFFF, 16'hFFFF, 1'b1},
    '{ROW_WRITE,        CFG_WIDTH_LOG2,     4'h1, 16'h0000, 16'h0000, 1'b0},
    '{ROW_FEED,         CFG_UNUSED,         4'h0, 16'h0000, 16'h0000, 1'b0},
    '{ROW_FEED_CHECKED, CFG_UNUSED,         4'h0, 16'h0001, 16'h0001, 1'b1},
    '{ROW_FEED,         CFG_UNUSED,         4'h0, 16'hFFFF, 16'h0000, 1'b0},
    '{ROW_FEED_CHECKED, CFG_UNUSED,         4'h0, 16'hFFFF, 16'hFFFF, 1'b1},
    '{ROW_WRITE,        CFG_HEIGHT_LOG2,    4'h1, 16'h0000, 16'h0000, 1'b0},
    '{ROW_FEED,         CFG_UNUSED,         4'h0, 16'h0001, 16'h0000, 1'b0},
    '{ROW_FEED,         CFG_UNUSED,         4'h0, 16'h0000, 16'h0000, 1'b0},
    '{ROW_FEED,         CFG_UNUSED,         4'h0, 16'h0000, 16'h0000, 1'b0},
    '{ROW_FEED_CHECKED, CFG_UNUSED,         4'h0, 16'h0000, 16'h0000, 1'b1},
    '{ROW_FEED,         CFG_UNUSED,         4'h0, 16'h0001, 16'h0000, 1'b0},
    '{ROW_FEED,         CFG_UNUSED,         4'h0, 16'h0001, 16'h0000, 1'b0},
    '{ROW_FEED,         CFG_UNUSED,         4'h0, 16'h0000, 16'h0000, 1'b0},
    '{ROW_FEED_CHECKED, CFG_UNUSED,         4'h0, 16'h0000, 16'h0001, 1'b1},
    '{ROW_WRITE,        CFG_WIDTH_LOG2,     4'h0, 16'h0000, 16'h0000, 1'b0},
    '{ROW_FEED,         CFG_UNUSED,         4'h0, 16'h0003, 16'h0000, 1'b0},
    '{ROW_FEED_CHECKED, CFG_UNUSED,         4'h0, 16'h0000, 16'h0002, 1'b1},
    '{ROW_WRITE,        CFG_THREE_CHANNELS, 4'hF, 16'h0000, 16'h0000, 1'b0},
    '{ROW_FEED,         CFG_UNUSED,         4'h0, 16'h0010, 16'h0000, 1'b0},
    '{ROW_FEED,         CFG_UNUSED,         4'h0, 16'h0020, 16'h0000, 1'b0},
    '{ROW_FEED,         CFG_UNUSED,         4'h0, 16'h0030, 16'h0000, 1'b0},
    '{ROW_FEED_CHECKED, CFG_UNUSED,         4'h0, 16'h0010, 16'h0010, 1'b0},
    '{ROW_FEED_CHECKED, CFG_UNUSED,         4'h0, 16'h0020, 16'h0020, 1'b0},
    '{ROW_FEED_CHECKED, CFG_UNUSED,         4'h0, 16'h0030, 16'h0030, 1'b1},
    '{ROW_WRITE,        CFG_HEIGHT_LOG2,    4'h0, 16'h0000, 16'h0000, 1'b0},
    '{ROW_FEED_CHECKED, CFG_UNUSED,         4'h0, 16'h1234, 16'h1234, 1'b0},
    '{ROW_WRITE,        CFG_UNUSED,         4'h5, 16'h0000, 16'h0000, 1'b0},
    '{ROW_FEED_CHECKED, CFG_UNUSED,         4'h0, 16'h5678, 16'h5678, 1'b0},
    '{ROW_FEED_CHECKED, CFG_UNUSED,         4'h0, 16'h9ABC, 16'h9ABC, 1'b1},
    '{ROW_WRITE,        CFG_WIDTH_LOG2,     4'hF, 16'h0000, 16'h0000, 1'b0},
    '{ROW_FEED,         CFG_UNUSED,         4'h0, 16'h8001, 16'h0000, 1'b0},
    '{ROW_FEED,         CFG_UNUSED,         4'h0, 16'h7FFE, 16'h0000, 1'b0},
    '{ROW_FEED,         CFG_UNUSED,         4'h0, 16'hFFFF, 16'h0000, 1'b0},
    '{ROW_FEED,         CFG_UNUSED,         4'h0, 16'h8000, 16'h0000, 1'b0},
    '{ROW_FEED,         CFG_UNUSED,         4'h0, 16'h0001, 16'h0000, 1'b0},
    '{ROW_FEED,         CFG_UNUSED,         4'h0, 16'hFFFF, 16'h0000, 1'b0}
  };

  logic                      clk;
  logic                      rst        = 1'b1;
  logic                      cfg_write  = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index  = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data   = '0;
  logic                      in_valid   = 1'b0;
  logic                      in_ready;
  logic [15:0]               sample     = '0;
  logic                      out_valid;
  logic                      out_ready  = 1'b0;
  logic [AVERAGE_BITS-1:0]   average;
  logic                      level_last;

  logic [17:0]  pair_line [LINE_SLOTS];
  logic [15:0]  left_held [3];
  int unsigned  col_pos   = 0;
  int unsigned  row_pos   = 0;
  int unsigned  chan_pos  = 0;
  logic [3:0]   width_sel  = '0;
  logic [3:0]   height_sel = '0;
  logic         chan3_sel  = 1'b0;

  quad_mean_t   quad_means_due [$];
  int           mismatches     = 0;
  int           averages_seen  = 0;
  int           samples_fed    = 0;
  int           settings_used  = 0;
  bit           tx_calm        = 1'b0;
  bit           rx_calm        = 1'b0;
  int           rx_hold        = 0;

  mip_box_downfilter_top uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample     (sample),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .average    (average),
    .level_last (level_last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic flag_mismatch(input string what);
    $display("MISMATCH: %s", what);
    mismatches++;
  endtask

  function automatic int pick_gap();
    if ($urandom_range(0, 15) < 12) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 24);
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Oversized widths fold down to the line store limit and heights to 4096.
  function automatic void level_shape(output int unsigned wid, output int unsigned hgt,
                                      output int unsigned nc);
    int unsigned e;
    e = width_sel;
    while (e > 0 && (32'd1 << e) > MAX_W) e--;
    wid = 32'd1 << e;
    e = height_sel;
    if (e > HEIGHT_LOG2_LIMIT) e = HEIGHT_LOG2_LIMIT;
    hgt = 32'd1 << e;
    nc = chan3_sel ? 3 : 1;
  endfunction

  task automatic accumulate_quad(input logic [15:0] s, input bit typed,
                                 input logic [15:0] t_avg, input bit t_last);
    int unsigned wid, hgt, nc, c, col, row, idx;
    logic [17:0] pair;
    logic [19:0] total;
    logic [19:0] rounded;
    bit          have_pair;
    bit          emit;
    quad_mean_t  due;
    level_shape(wid, hgt, nc);
    c = chan_pos;
    col = col_pos;
    row = row_pos;
    if (c >= nc) c = 0;
    if (col >= wid) col = 0;
    if (row >= hgt) row = 0;
    pair = '0;
    total = '0;
    have_pair = 1'b0;
    emit = 1'b0;
    if (wid == 1) begin
      pair = {2'b00, s} + {2'b00, s};
      have_pair = 1'b1;
    end else if (col % 2 == 0) begin
      left_held[c] = s;
    end else begin
      pair = {2'b00, left_held[c]} + {2'b00, s};
      have_pair = 1'b1;
    end
    if (have_pair) begin
      idx = (col >> 1) * nc + c;
      if (hgt == 1) begin
        total = {2'b00, pair} + {2'b00, pair};
        emit = 1'b1;
      end else if (idx < LINE_SLOTS) begin
        if (row % 2 == 0) begin
          pair_line[idx] = pair;
        end else begin
          total = {2'b00, pair_line[idx]} + {2'b00, pair};
          emit = 1'b1;
        end
      end
    end
    if (typed) begin
      due.avg = t_avg;
      due.last = t_last;
      quad_means_due.push_back(due);
    end else if (emit) begin
      rounded = (total + 20'd2) >> 2;
      due.avg = rounded[15:0];
      due.last = (row == hgt - 1) && (col == wid - 1) && (c == nc - 1);
      quad_means_due.push_back(due);
    end
    c++;
    if (c >= nc) begin
      c = 0;
      col++;
      if (col >= wid) begin
        col = 0;
        row++;
        if (row >= hgt) row = 0;
      end
    end
    chan_pos = c;
    col_pos = col;
    row_pos = row;
  endtask

  // Returns at the edge that accepts the beat, with in_valid still high.
  task automatic feed_sample(input logic [15:0] s);
    int gap;
    gap = 0;
    if (!tx_calm && $urandom_range(0, 2) == 0) gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= s;
    do @(posedge clk); while (!in_ready);
    samples_fed++;
  endtask

  // Leaves cfg_write high; the caller lowers it after the last write.
  task automatic write_reg(input cfg_index_t sel, input logic [3:0] value);
    cfg_write <= 1'b1;
    cfg_index <= sel;
    cfg_data <= value;
    @(posedge clk);
    case (sel)
      CFG_WIDTH_LOG2:     width_sel = value;
      CFG_HEIGHT_LOG2:    height_sel = value;
      CFG_THREE_CHANNELS: chan3_sel = value[0];
      default: ;
    endcase
    if (sel != CFG_UNUSED) begin
      chan_pos = 0;
      col_pos = 0;
      row_pos = 0;
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (quad_means_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_level(input logic [3:0] wl, input logic [3:0] hl,
                               input logic [3:0] chv);
    cfg_index_t order [3];
    cfg_index_t held;
    int         k;
    int         j;
    order[0] = CFG_WIDTH_LOG2;
    order[1] = CFG_HEIGHT_LOG2;
    order[2] = CFG_THREE_CHANNELS;
    for (k = 2; k > 0; k--) begin
      j = $urandom_range(0, k);
      held = order[k];
      order[k] = order[j];
      order[j] = held;
    end
    if ($urandom_range(0, 5) == 0) write_reg(CFG_UNUSED, 4'($urandom));
    for (k = 0; k < 3; k++) begin
      case (order[k])
        CFG_WIDTH_LOG2:  write_reg(order[k], wl);
        CFG_HEIGHT_LOG2: write_reg(order[k], hl);
        default:         write_reg(order[k], chv);
      endcase
    end
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  always @(posedge clk) begin
    if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
    end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      rx_hold <= pick_gap();
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    quad_mean_t due;
    if (!rst && out_valid && out_ready) begin
      averages_seen++;
      if (quad_means_due.size() == 0) begin
        flag_mismatch($sformatf("average %h arrived with none pending", average));
      end else begin
        due = quad_means_due.pop_front();
        if (average !== due.avg) begin
          flag_mismatch($sformatf("average %h, wanted %h", average, due.avg));
        end
        if (level_last !== due.last) begin
          flag_mismatch($sformatf("level_last %b, wanted %b", level_last, due.last));
        end
      end
    end
  end

  initial begin
    plan_row_t   row;
    int          r;
    int          phase;
    int          big_done;
    int          random_beats;
    int          count;
    int          waited;
    int unsigned wid, hgt, nc;
    logic [3:0]  wl;
    logic [3:0]  hl;
    logic [15:0] s;
    phase = 0;
    big_done = 0;
    random_beats = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (r = 0; r < PLAN_ROWS; r++) begin
      row = PLAN[r];
      case (row.kind)
        ROW_WRITE: begin
          settle();
          write_reg(row.reg_sel, row.value);
          cfg_write <= 1'b0;
        end
        ROW_FEED: begin
          feed_sample(row.smp);
          accumulate_quad(row.smp, 1'b0, 16'h0000, 1'b0);
        end
        default: begin
          feed_sample(row.smp);
          accumulate_quad(row.smp, 1'b1, row.avg, row.last);
        end
      endcase
    end

    // Every fourth setting early on is one of the full-size levels, fed only
    // partway; the rest stay small and sometimes stop partway through a level.
    while (random_beats < RANDOM_BEATS || big_done < 3) begin
      settle();
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      if (phase % 4 == 3 && big_done < 3) begin
        case (big_done)
          0: program_level(4'd15, 4'd0, 4'd8);
          1: program_level(4'd0, 4'd13, 4'd6);
          default: program_level(4'd12, 4'd1, 4'd7);
        endcase
        big_done++;
        count = $urandom_range(48, 120);
        random_beats += count;
      end else begin
        wl = $urandom_range(0, 5);
        hl = $urandom_range(0, 6 - wl);
        program_level(wl, hl, 4'($urandom));
        level_shape(wid, hgt, nc);
        count = wid * hgt * nc;
        if ($urandom_range(0, 3) == 0) begin
          count = $urandom_range(1, count);
        end else begin
          count = count * $urandom_range(1, 2);
        end
        random_beats += count;
      end
      repeat (count) begin
        s = pick_sample();
        feed_sample(s);
        accumulate_quad(s, 1'b0, 16'h0000, 1'b0);
      end
      phase++;
    end

    in_valid <= 1'b0;
    waited = 0;
    while (quad_means_due.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (quad_means_due.size() != 0) begin
      flag_mismatch($sformatf("%0d averages never arrived", quad_means_due.size()));
    end
    $display("Fed %0d samples under %0d level settings, some 4096 wide or tall.",
             samples_fed, settings_used);
    $display("Compared %0d averages with %0d mismatches.", averages_seen, mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
